@@ hw/rtl/cpt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_pkg
// Types and codes shared by the pairwise tally front end, queue and engine.
// ---------------------------------------------------------------------------
package cpt_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [1:0] {
		OP_ENTRY  = 2'd0,
		OP_REPORT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_TALLIED  = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_ROW      = 2'd2,
		KIND_CLEARED  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		B_INIT,
		B_IDLE,
		B_CLR,
		B_ROW,
		B_ROWW,
		B_RDR,
		B_RDC,
		B_UPD,
		B_REPRD,
		B_REPCMP,
		B_EMIT
	} back_state_t;

	// One classified request passed from the front end to the engine.
	typedef struct packed {
		op_t                op;
		logic [4:0]         cand;
		logic signed [15:0] rate;
		logic               store;
		logic               closing;
		logic               bad;
	} cmd_t;

endpackage

@@ hw/rtl/cpt_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_queue
// Short request queue between the front end and the tally engine.
// ---------------------------------------------------------------------------
module cpt_queue
	import cpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic ready,
	input  logic pop,
	output logic nonempty,
	output cmd_t head
);

	cmd_t             slot_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QAW:0]     cnt_q;

	assign ready    = (cnt_q < (QAW+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/cpt_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_front
// Accepts requests, screens ballot entries and forwards classified requests.
// ---------------------------------------------------------------------------
module cpt_front
	import cpt_pkg::*;
#(
	parameter int MAX_CANDIDATES     = 32,
	parameter int MAX_BALLOT_ENTRIES = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             opcode,
	input  logic [4:0]                             candidate,
	input  logic signed [15:0]                     rating,
	input  logic                                   last_of_ballot,
	input  logic [$clog2(MAX_CANDIDATES+1)-1:0]    n_active,
	input  logic                                   engine_init,
	input  logic                                   q_ready,
	output logic                                   push,
	output cmd_t                                   push_cmd
);

	localparam int CW = $clog2(MAX_CANDIDATES);
	localparam int LW = $clog2(MAX_BALLOT_ENTRIES + 1);

	logic [MAX_CANDIDATES-1:0] listed_q;
	logic [LW-1:0]             len_q;
	logic                      bad_q;
	logic                      accept;
	logic                      is_entry;
	logic                      in_range;
	logic [CW-1:0]             cidx;
	logic                      ok;

	assign in_stall = !q_ready || engine_init;
	assign accept   = in_valid && !in_stall;
	assign is_entry = (op_t'(opcode) == OP_ENTRY);
	assign in_range = (8'(candidate) < 8'(n_active));
	assign cidx     = CW'(candidate);
	assign ok       = in_range && !listed_q[cidx] && (len_q < LW'(MAX_BALLOT_ENTRIES));

	assign push = accept && (op_t'(opcode) != OP_NONE);

	always_comb begin
		push_cmd.op      = op_t'(opcode);
		push_cmd.cand    = candidate;
		push_cmd.rate    = rating;
		push_cmd.store   = is_entry && ok;
		push_cmd.closing = is_entry && last_of_ballot;
		push_cmd.bad     = bad_q || !ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
			len_q    <= '0;
			bad_q    <= 1'b0;
		end else if (accept && is_entry) begin
			if (last_of_ballot) begin
				// drop the ballot bookkeeping once it is closed
				listed_q <= '0;
				len_q    <= '0;
				bad_q    <= 1'b0;
			end else if (ok) begin
				listed_q[cidx] <= 1'b1;
				len_q          <= len_q + 1'b1;
			end else begin
				bad_q <= 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/cpt_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_back
// Tally engine: holds the ballot ratings and the pairwise count memory,
// commits ballots, sweeps reports and clears, drives the result register.
// ---------------------------------------------------------------------------
module cpt_back
	import cpt_pkg::*;
#(
	parameter int MAX_CANDIDATES = 32,
	parameter int COUNT_WIDTH    = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(MAX_CANDIDATES+1)-1:0] n_active,
	input  logic                                q_nonempty,
	input  cmd_t                                q_head,
	output logic                                q_pop,
	output logic                                engine_init,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          kind,
	output logic [4:0]                          which_candidate,
	output logic [4:0]                          defeats,
	output logic                                undefeated,
	output logic                                last
);

	localparam int CW    = $clog2(MAX_CANDIDATES);
	localparam int NW    = $clog2(MAX_CANDIDATES + 1);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [CW-1:0]          CMAX  = CW'(MAX_CANDIDATES - 1);
	localparam logic [COUNT_WIDTH-1:0] FULL  = '1;

	back_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0]    pair_mem [DEPTH];
	logic signed [15:0]        rate_mem [MAX_CANDIDATES];

	logic [COUNT_WIDTH-1:0]    pc_a, pc_b;
	logic signed [15:0]        rate_rd;
	logic signed [15:0]        ra_q;

	logic [MAX_CANDIDATES-1:0] listed_q;
	logic [CW-1:0]             a_q, c_q, i_q, j_q;
	logic [AW-1:0]             idx_q, cell_q;
	logic [4:0]                d_q;
	logic                      commit_q, full_q, hit_q;

	kind_t                     pend_kind_q;
	logic [4:0]                pend_cand_q, pend_def_q;
	logic                      pend_last_q;

	logic                      out_valid_q;
	kind_t                     out_kind_q;
	logic [4:0]                out_cand_q, out_def_q;
	logic                      out_last_q;

	logic [AW-1:0]             pa_addr, pb_addr, pw_addr;
	logic                      pw_en;
	logic [COUNT_WIDTH-1:0]    pw_data;
	logic [CW-1:0]             rr_addr;
	logic                      rw_en;
	logic [CW-1:0]             head_idx;

	logic                      hit_c, c_listed, last_a, last_c, full_now, out_free;
	logic [AW-1:0]             cell_c;
	back_state_t               pass_end;
	logic                      j_last, i_last;
	logic [4:0]                d_new;

	assign head_idx = CW'(q_head.cand);
	assign c_listed = listed_q[c_q];
	assign hit_c    = c_listed ? (ra_q > rate_rd)
	                           : (NW'(c_q) < n_active);
	assign cell_c   = (c_listed || !ra_q[15]) ? {a_q, c_q} : {c_q, a_q};
	assign last_a   = (a_q == CMAX);
	assign last_c   = (c_q == CMAX);
	assign full_now = full_q || ((state_q == B_UPD) && hit_q && !commit_q && (pc_a == FULL));
	assign pass_end = (!commit_q && !full_now) ? B_ROW : B_EMIT;
	assign out_free = !out_valid_q || !out_stall;
	assign j_last   = (NW'(j_q) == n_active - 1'b1);
	assign i_last   = (NW'(i_q) == n_active - 1'b1);
	assign d_new    = ((j_q != i_q) && (pc_a > pc_b) && (d_q != 5'd31)) ? d_q + 1'b1 : d_q;

	assign engine_init = (state_q == B_INIT);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rr_addr = a_q;
		pa_addr = {a_q, c_q};
		pb_addr = {i_q, j_q};
		pw_en   = 1'b0;
		pw_addr = idx_q;
		pw_data = '0;
		rw_en   = 1'b0;
		unique case (state_q) inside
			B_INIT, B_CLR: begin
				pw_en = 1'b1;
				if (idx_q == '1) begin
					state_d = (state_q == B_INIT) ? B_IDLE : B_EMIT;
				end
			end
			B_IDLE: begin
				if (q_nonempty) begin
					q_pop = 1'b1;
					case (q_head.op)
						OP_ENTRY: begin
							rw_en = q_head.store;
							if (q_head.closing) begin
								state_d = q_head.bad ? B_EMIT : B_ROW;
							end
						end
						OP_REPORT: state_d = B_REPRD;
						OP_CLEAR:  state_d = B_CLR;
						default:   state_d = B_IDLE;
					endcase
				end
			end
			B_ROW: begin
				rr_addr = a_q;
				if (listed_q[a_q]) begin
					state_d = B_ROWW;
				end else if (last_a) begin
					state_d = pass_end;
				end
			end
			B_ROWW: state_d = B_RDR;
			B_RDR: begin
				rr_addr = c_q;
				state_d = B_RDC;
			end
			B_RDC: begin
				pa_addr = cell_c;
				state_d = B_UPD;
			end
			B_UPD: begin
				if (hit_q && commit_q) begin
					pw_en   = 1'b1;
					pw_addr = cell_q;
					pw_data = pc_a + 1'b1;
				end
				if (!last_c) begin
					state_d = B_RDR;
				end else if (last_a) begin
					state_d = pass_end;
				end else begin
					state_d = B_ROW;
				end
			end
			B_REPRD: begin
				pa_addr = {j_q, i_q};
				pb_addr = {i_q, j_q};
				state_d = B_REPCMP;
			end
			B_REPCMP: state_d = j_last ? B_EMIT : B_REPRD;
			B_EMIT: begin
				if (out_free) begin
					state_d = (pend_kind_q == KIND_ROW && !pend_last_q) ? B_REPRD : B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pw_en) begin
			pair_mem[pw_addr] <= pw_data;
		end
		pc_a <= pair_mem[pa_addr];
		pc_b <= pair_mem[pb_addr];
	end

	always_ff @(posedge clk) begin
		if (rw_en) begin
			rate_mem[head_idx] <= q_head.rate;
		end
		rate_rd <= rate_mem[rr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q    <= '0;
			a_q         <= '0;
			c_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			idx_q       <= '0;
			cell_q      <= '0;
			d_q         <= '0;
			ra_q        <= '0;
			commit_q    <= 1'b0;
			full_q      <= 1'b0;
			hit_q       <= 1'b0;
			pend_kind_q <= KIND_TALLIED;
			pend_cand_q <= '0;
			pend_def_q  <= '0;
			pend_last_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_TALLIED;
			out_cand_q  <= '0;
			out_def_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != B_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q) inside
				B_INIT, B_CLR: begin
					idx_q       <= idx_q + 1'b1;
					pend_kind_q <= KIND_CLEARED;
					pend_cand_q <= '0;
					pend_def_q  <= '0;
					pend_last_q <= 1'b1;
				end
				B_IDLE: begin
					if (q_nonempty) begin
						case (q_head.op)
							OP_ENTRY: begin
								if (q_head.store && !(q_head.closing && q_head.bad)) begin
									listed_q[head_idx] <= 1'b1;
								end
								if (q_head.closing) begin
									a_q         <= '0;
									commit_q    <= 1'b0;
									full_q      <= 1'b0;
									pend_kind_q <= KIND_REJECTED;
									pend_cand_q <= '0;
									pend_def_q  <= '0;
									pend_last_q <= 1'b1;
									if (q_head.bad) begin
										listed_q <= '0;
									end
								end
							end
							OP_REPORT: begin
								i_q <= '0;
								j_q <= '0;
								d_q <= '0;
							end
							OP_CLEAR: idx_q <= '0;
							default: ;
						endcase
					end
				end
				B_ROW, B_UPD: begin
					if (state_q == B_UPD && hit_q && !commit_q && pc_a == FULL) begin
						full_q <= 1'b1;
					end
					if (state_q == B_UPD && !last_c) begin
						c_q <= c_q + 1'b1;
					end else if (state_q == B_ROW && listed_q[a_q]) begin
						// row is listed: walk its columns next
					end else if (!last_a) begin
						a_q <= a_q + 1'b1;
					end else if (!commit_q && !full_now) begin
						// check pass clean: start the commit pass
						commit_q <= 1'b1;
						a_q      <= '0;
					end else begin
						pend_kind_q <= full_now ? KIND_REJECTED : KIND_TALLIED;
						listed_q    <= '0;
					end
				end
				B_ROWW: begin
					ra_q <= rate_rd;
					c_q  <= '0;
				end
				B_RDC: begin
					hit_q  <= hit_c;
					cell_q <= cell_c;
				end
				B_REPCMP: begin
					if (j_last) begin
						pend_kind_q <= KIND_ROW;
						pend_cand_q <= 5'(i_q);
						pend_def_q  <= d_new;
						pend_last_q <= i_last;
						d_q         <= '0;
						j_q         <= '0;
					end else begin
						d_q <= d_new;
						j_q <= j_q + 1'b1;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= pend_kind_q;
						out_cand_q  <= pend_cand_q;
						out_def_q   <= pend_def_q;
						out_last_q  <= pend_last_q;
						if (pend_kind_q == KIND_ROW && !pend_last_q) begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_kind_q;
	assign which_candidate = out_cand_q;
	assign defeats         = out_def_q;
	assign undefeated      = (out_kind_q == KIND_ROW) && (out_def_q == '0);
	assign last            = out_last_q;

endmodule

@@ hw/rtl/condorcet_pairwise_tally_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// condorcet_pairwise_tally_top
// Pairwise preference tally with ballot buffering, defeat reports and clear.
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  config   | cfg_we              | cfg_wdata (num_candidates)
//  request  | in_valid / in_stall | opcode, candidate, rating, last_of_ballot
//  result   | out_valid/out_stall | kind, which_candidate, defeats, undefeated,
//           |                     | last
//
//  A ballot entry without the closing mark leaves the engine in its idle state.
//  Closing a ballot walks rows x columns of MAX_CANDIDATES, with read, compare
//  and update steps per column of a listed row, once to check for full counts
//  and, if none is full, once to add. A report reads two counts per compare.
//  A clear, and the pass after reset, sweep the count memory one word a cycle:
//  4**ceil(log2(MAX_CANDIDATES)) words, 1024 at the default; in_stall is high
//  through the pass after reset.
//  A stalled result holds the engine; a four deep queue absorbs requests.
// ---------------------------------------------------------------------------
module condorcet_pairwise_tally_top
	import cpt_pkg::*;
#(
	parameter int MAX_CANDIDATES     = 32,
	parameter int MAX_BALLOT_ENTRIES = 32,
	parameter int COUNT_WIDTH        = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [4:0]         candidate,
	input  logic signed [15:0] rating,
	input  logic               last_of_ballot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [4:0]         which_candidate,
	output logic [4:0]         defeats,
	output logic               undefeated,
	output logic               last
);

	localparam int NW = $clog2(MAX_CANDIDATES + 1);

	logic [5:0]    num_cand_q;
	logic [NW-1:0] n_active;
	logic          push, pop, q_ready, q_nonempty, engine_init;
	cmd_t          push_cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cand_q <= 6'd32;
		end else if (cfg_we) begin
			num_cand_q <= cfg_wdata;
		end
	end

	// zero acts as one, values above the array size clamp to it
	always_comb begin
		if (num_cand_q == '0) begin
			n_active = NW'(1);
		end else if (8'(num_cand_q) > 8'(MAX_CANDIDATES)) begin
			n_active = NW'(MAX_CANDIDATES);
		end else begin
			n_active = NW'(num_cand_q);
		end
	end

	cpt_front #(
		.MAX_CANDIDATES    (MAX_CANDIDATES),
		.MAX_BALLOT_ENTRIES(MAX_BALLOT_ENTRIES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.candidate     (candidate),
		.rating        (rating),
		.last_of_ballot(last_of_ballot),
		.n_active      (n_active),
		.engine_init   (engine_init),
		.q_ready       (q_ready),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	cpt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.ready   (q_ready),
		.pop     (pop),
		.nonempty(q_nonempty),
		.head    (head)
	);

	cpt_back #(
		.MAX_CANDIDATES(MAX_CANDIDATES),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.n_active       (n_active),
		.q_nonempty     (q_nonempty),
		.q_head         (head),
		.q_pop          (pop),
		.engine_init    (engine_init),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.which_candidate(which_candidate),
		.defeats        (defeats),
		.undefeated     (undefeated),
		.last           (last)
	);

endmodule

@@ hw/rtl/cpt_chk.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpt_chk
// Port level checks for the pairwise tally block.
// ---------------------------------------------------------------------------
module cpt_chk
	import cpt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [4:0] which_candidate,
	input logic [4:0] defeats,
	input logic       undefeated,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(defeats))
		else $error("stalled result changed");

	a_undef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ROW |-> undefeated == (defeats == 5'd0))
		else $error("undefeated flag disagrees with defeat count");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ROW |-> last && !undefeated && defeats == 5'd0
			&& which_candidate == 5'd0)
		else $error("single result carries report fields");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind == KIND_ROW && !last ##1 out_valid
			|-> kind == KIND_ROW && which_candidate == $past(which_candidate) + 5'd1)
		else $error("report rows out of order");

endmodule

bind condorcet_pairwise_tally_top cpt_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.kind           (kind),
	.which_candidate(which_candidate),
	.defeats        (defeats),
	.undefeated     (undefeated),
	.last           (last)
);
